[design/esa_pkg.sv]
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types and constants of the encoder step accelerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esa_pkg;

    localparam int ESA_HISTORY_DEPTH = 8;

    localparam int TIME_W  = 48;
    localparam int POS_W   = 16;
    localparam int THR_W   = 16;
    localparam int SIZE_W  = 8;
    localparam int STEP_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_STEP   = 3'd5;

    localparam logic [TIME_W-1:0] RST_RESET_TIMEOUT = 48'd10000000;
    localparam logic [TIME_W-1:0] RST_WINDOW        = 48'd500000;
    localparam logic [THR_W-1:0]  RST_FAST_THR      = 16'd25;
    localparam logic [THR_W-1:0]  RST_MEDIUM_THR    = 16'd15;
    localparam logic [SIZE_W-1:0] RST_FAST_STEP     = 8'd15;
    localparam logic [SIZE_W-1:0] RST_MEDIUM_STEP   = 8'd5;

    typedef struct packed {
        logic [TIME_W-1:0]       time_us;
        logic signed [POS_W-1:0] position;
        logic                    batch_end;
    } in_word_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] step;
        logic                     counter_reset;
        logic signed [POS_W-1:0]  batch_total;
        logic                     total_ready;
    } out_word_t;

    typedef struct packed {
        logic                    en;
        logic [TIME_W-1:0]       time_us;
        logic signed [POS_W-1:0] position;
    } hist_wr_t;

endpackage

`default_nettype wire

[design/esa_hist.sv]
// ----------------------------------------------------------------------------
// esa_hist
// Circular history of position and time pairs, one write and one
// registered read per cycle; entries not yet written read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esa_hist
    import esa_pkg::*;
#(
    parameter int DEPTH = ESA_HISTORY_DEPTH,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hist_wr_t                wr,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic                    rd_en,
    input  wire logic [AW-1:0]           rd_addr,
    output logic [TIME_W-1:0]            rd_time,
    output logic signed [POS_W-1:0]      rd_pos
);

    logic [TIME_W-1:0]       mem_time [DEPTH];
    logic signed [POS_W-1:0] mem_pos  [DEPTH];
    logic [DEPTH-1:0]        valid_reg;
    logic [TIME_W-1:0]       rd_time_reg;
    logic signed [POS_W-1:0] rd_pos_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_time[wr_addr] <= wr.time_us;
            mem_pos[wr_addr]  <= wr.position;
        end
        if (rd_en)
        begin
            rd_time_reg <= mem_time[rd_addr];
            rd_pos_reg  <= mem_pos[rd_addr];
        end
    end

    assign rd_time = rd_valid_reg ? rd_time_reg : '0;
    assign rd_pos  = rd_valid_reg ? rd_pos_reg : '0;

endmodule

`default_nettype wire

[design/encoder_step_accelerator.sv]
// ----------------------------------------------------------------------------
// encoder_step_accelerator
// The history walk visits one entry per cycle through a single 48-bit gap
// comparator. A new input word is accepted only in the idle state, once the
// output word of the previous one has been loaded.
// Reset: history reads as zero, batch sum cleared, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module encoder_step_accelerator
    import esa_pkg::*;
#(
    parameter int HISTORY_DEPTH = ESA_HISTORY_DEPTH,
    localparam int AW = $clog2(HISTORY_DEPTH)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_word_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_word_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GAP  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    logic [2:0] state_reg, state_next;

    logic [TIME_W-1:0] timeout_reg, window_reg;
    logic [THR_W-1:0]  fast_thr_reg, medium_thr_reg;
    logic [SIZE_W-1:0] fast_step_reg, medium_step_reg;

    logic [TIME_W-1:0]        now_reg, last_time_reg;
    logic signed [POS_W-1:0]  in_pos_reg, pos0_reg, prev_pos_reg;
    logic                     last_reg, rst_flag_reg, lone_reg;
    logic [AW-1:0]            idx_reg, head_reg, rd_ptr_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [POS_W-1:0]  batch_sum_reg;
    logic                     out_valid_reg;
    out_word_t                out_data_reg;

    hist_wr_t                wr;
    logic [AW-1:0]           head_inc, rd_dec;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [TIME_W-1:0]       rd_time;
    logic signed [POS_W-1:0] rd_pos;

    logic [TIME_W-1:0]       gap_then, gap_lim, gap_diff;
    logic                    gap_borrow, gap_hit;
    logic signed [POS_W-1:0] new_pos;

    logic signed [POS_W:0]    chg;
    logic [POS_W:0]           mag17;
    logic [POS_W-1:0]         mag;
    logic [SIZE_W-1:0]        size;
    logic signed [STEP_W-1:0] size9, step_val;

    logic signed [POS_W:0]   sum17;
    logic signed [POS_W-1:0] sum_sat;
    logic                    load_out;

    // shared gap unit
    assign gap_then = (state_reg == S_GAP) ? last_time_reg : rd_time;
    assign gap_lim  = (state_reg == S_GAP) ? timeout_reg : window_reg;
    assign {gap_borrow, gap_diff} = {1'b0, now_reg} - {1'b0, gap_then};
    assign gap_hit  = !gap_borrow && (gap_diff > gap_lim);

    assign new_pos  = gap_hit ? '0 : in_pos_reg;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign rd_dec   = (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - 1'b1;

    always_comb
    begin
        wr.en       = (state_reg == S_GAP);
        wr.time_us  = now_reg;
        wr.position = new_pos;
        rd_en       = 1'b0;
        rd_addr     = rd_dec;
        if (state_reg == S_GAP)
        begin
            rd_en   = 1'b1;
            rd_addr = head_reg;
        end
        else if (state_reg == S_WALK && !gap_hit && idx_reg != LAST_IDX)
        begin
            rd_en   = 1'b1;
            rd_addr = rd_dec;
        end
    end

    esa_hist #(
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_addr (head_inc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_pos  (rd_pos)
    );

    // step size from the change
    assign chg   = {pos0_reg[POS_W-1], pos0_reg} - {prev_pos_reg[POS_W-1], prev_pos_reg};
    assign mag17 = chg[POS_W] ? 17'(-chg) : 17'(chg);
    assign mag   = mag17[POS_W-1:0];

    always_comb
    begin
        if (mag >= fast_thr_reg)
        begin
            size = fast_step_reg;
        end
        else if (mag >= medium_thr_reg)
        begin
            size = medium_step_reg;
        end
        else
        begin
            size = SIZE_W'(1);
        end
        size9 = $signed({1'b0, size});
        if (lone_reg)
        begin
            step_val = (pos0_reg > 0) ? 9'sd1 : -9'sd1;
        end
        else
        begin
            step_val = chg[POS_W] ? -size9 : size9;
        end
    end

    // saturating batch sum
    assign sum17 = {batch_sum_reg[POS_W-1], batch_sum_reg}
                 + {{(POS_W + 1 - STEP_W){step_reg[STEP_W-1]}}, step_reg};
    always_comb
    begin
        if (sum17[POS_W] != sum17[POS_W-1])
        begin
            sum_sat = sum17[POS_W] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            sum_sat = sum17[POS_W-1:0];
        end
    end

    assign load_out = (state_reg == S_SUM) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (gap_hit || idx_reg == LAST_IDX)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            timeout_reg     <= RST_RESET_TIMEOUT;
            window_reg      <= RST_WINDOW;
            fast_thr_reg    <= RST_FAST_THR;
            medium_thr_reg  <= RST_MEDIUM_THR;
            fast_step_reg   <= RST_FAST_STEP;
            medium_step_reg <= RST_MEDIUM_STEP;
            last_time_reg   <= '0;
            head_reg        <= '0;
            batch_sum_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESET_TIMEOUT: timeout_reg     <= cfg_data;
                    CFG_WINDOW:        window_reg      <= cfg_data;
                    CFG_FAST_THR:      fast_thr_reg    <= cfg_data[THR_W-1:0];
                    CFG_MEDIUM_THR:    medium_thr_reg  <= cfg_data[THR_W-1:0];
                    CFG_FAST_STEP:     fast_step_reg   <= cfg_data[SIZE_W-1:0];
                    CFG_MEDIUM_STEP:   medium_step_reg <= cfg_data[SIZE_W-1:0];
                    default:           ;
                endcase
            end
            if (state_reg == S_GAP)
            begin
                last_time_reg <= now_reg;
                head_reg      <= head_inc;
            end
            if (load_out)
            begin
                batch_sum_reg <= last_reg ? '0 : sum_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                now_reg    <= in_data.time_us;
                in_pos_reg <= in_data.position;
                last_reg   <= in_data.batch_end;
            end
            S_GAP:
            begin
                rst_flag_reg <= gap_hit;
                pos0_reg     <= new_pos;
                prev_pos_reg <= new_pos;
                lone_reg     <= 1'b0;
                rd_ptr_reg   <= head_reg;
                idx_reg      <= AW'(1);
            end
            S_WALK:
            begin
                if (gap_hit)
                begin
                    lone_reg <= (idx_reg == AW'(1));
                end
                else
                begin
                    prev_pos_reg <= rd_pos;
                    rd_ptr_reg   <= rd_dec;
                    idx_reg      <= idx_reg + 1'b1;
                end
            end
            S_STEP:
            begin
                step_reg <= step_val;
            end
            S_SUM:
            begin
                if (load_out)
                begin
                    out_data_reg.step          <= step_reg;
                    out_data_reg.counter_reset <= rst_flag_reg;
                    out_data_reg.batch_total   <= sum_sat;
                    out_data_reg.total_ready   <= last_reg && (sum_sat != '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_GAP)
        else $error("accepted word did not start gap check");

    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> (idx_reg != '0 && idx_reg <= LAST_IDX))
        else $error("history walk index out of range");

    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM && out_valid && !out_ready |=> state_reg == S_SUM)
        else $error("result dropped while output stalled");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && last_reg |=> batch_sum_reg == '0)
        else $error("batch sum not cleared at batch end");
`endif

endmodule

`default_nettype wire

[bench/encoder_step_accelerator_tb.sv]
// ----------------------------------------------------------------------------
// encoder_step_accelerator_tb
// Self-checking bench for the encoder step accelerator. Directed events walk
// the corner cases first: the whole history inside the window, lone events,
// backwards time, counter reset at and past the timeout, and extreme
// positions. Random phases then run the block under several register
// settings, the limits among them, and drive two long batches into
// saturation. A built-in predictor follows every accepted event, and each
// output word is compared field by field. Random gaps are inserted on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_step_accelerator_tb;

    import esa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] window;
        logic [THR_W-1:0]  fast_thr;
        logic [THR_W-1:0]  medium_thr;
        logic [SIZE_W-1:0] fast_size;
        logic [SIZE_W-1:0] medium_size;
    } accel_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    accel_cfg_t              live_cfg;
    logic signed [POS_W-1:0] hist_pos [ESA_HISTORY_DEPTH];
    logic [TIME_W-1:0]       hist_time [ESA_HISTORY_DEPTH];
    int                      batch_acc;
    out_word_t               pending_steps [$];

    logic [TIME_W-1:0] cur_time;
    logic [POS_W-1:0]  cur_pos;
    bit                gaps_on;
    int                stall_left;
    int                fail_count;
    out_word_t         want;
    out_word_t         got;

    encoder_step_accelerator u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic bit aged_out(input logic [TIME_W-1:0] t_now,
                                    input logic [TIME_W-1:0] t_prev,
                                    input logic [TIME_W-1:0] limit);
        return (t_now > t_prev) && ((t_now - t_prev) > limit);
    endfunction

    function automatic accel_cfg_t pack_regs(input logic [TIME_W-1:0] timeout,
                                             input logic [TIME_W-1:0] window,
                                             input logic [THR_W-1:0]  fast_thr,
                                             input logic [THR_W-1:0]  medium_thr,
                                             input logic [SIZE_W-1:0] fast_size,
                                             input logic [SIZE_W-1:0] medium_size);
        accel_cfg_t c;
        c.timeout     = timeout;
        c.window      = window;
        c.fast_thr    = fast_thr;
        c.medium_thr  = medium_thr;
        c.fast_size   = fast_size;
        c.medium_size = medium_size;
        return c;
    endfunction

    task automatic predict_step(input in_word_t w);
        logic      do_reset;
        int        used;
        int        i;
        int        p_new;
        int        p_old;
        int        change;
        int        mag;
        int        size;
        int        stp;
        int        total;
        out_word_t r;
        for (i = ESA_HISTORY_DEPTH - 1; i > 0; i--)
        begin
            hist_pos[i]  = hist_pos[i - 1];
            hist_time[i] = hist_time[i - 1];
        end
        do_reset     = aged_out(w.time_us, hist_time[0], live_cfg.timeout);
        hist_pos[0]  = do_reset ? '0 : w.position;
        hist_time[0] = w.time_us;
        used = ESA_HISTORY_DEPTH;
        for (i = ESA_HISTORY_DEPTH - 1; i >= 0; i--)
            if (aged_out(w.time_us, hist_time[i], live_cfg.window))
                used = i;
        p_new = hist_pos[0];
        if (used <= 1)
            stp = (p_new > 0) ? 1 : -1;
        else
        begin
            p_old  = hist_pos[used - 1];
            change = p_new - p_old;
            mag    = (change < 0) ? -change : change;
            if (mag >= int'(live_cfg.fast_thr))
                size = int'(live_cfg.fast_size);
            else if (mag >= int'(live_cfg.medium_thr))
                size = int'(live_cfg.medium_size);
            else
                size = 1;
            stp = (change >= 0) ? size : -size;
        end
        total = batch_acc + stp;
        if (total > 32767)
            total = 32767;
        if (total < -32768)
            total = -32768;
        r.step          = STEP_W'(stp);
        r.counter_reset = do_reset;
        r.batch_total   = POS_W'(total);
        r.total_ready   = w.batch_end && (total != 0);
        batch_acc = w.batch_end ? 0 : total;
        pending_steps.push_back(r);
    endtask

    task automatic send_word(input logic [TIME_W-1:0] t, input logic [POS_W-1:0] p,
                             input logic fin);
        in_word_t w;
        int       gap;
        w.time_us   = t;
        w.position  = p;
        w.batch_end = fin;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_step(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (ESA_HISTORY_DEPTH + 4) @(posedge clk);
    endtask

    task automatic apply_cfg(input accel_cfg_t c, input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CFG_W-1:0]     val [8];
        int                   n;
        int                   k;
        n = 0;
        if (poke_unused)
        begin
            idx[0] = CFG_UNUSED_LO;
            val[0] = CFG_W'({$urandom, $urandom});
            idx[1] = CFG_UNUSED_HI;
            val[1] = {CFG_W{1'b1}};
            n = 2;
        end
        idx[n] = CFG_RESET_TIMEOUT;
        val[n] = c.timeout;
        idx[n + 1] = CFG_WINDOW;
        val[n + 1] = c.window;
        idx[n + 2] = CFG_FAST_THR;
        val[n + 2] = {32'($urandom), c.fast_thr};
        idx[n + 3] = CFG_MEDIUM_THR;
        val[n + 3] = {32'($urandom), c.medium_thr};
        idx[n + 4] = CFG_FAST_STEP;
        val[n + 4] = {8'($urandom), 32'($urandom), c.fast_size};
        idx[n + 5] = CFG_MEDIUM_STEP;
        val[n + 5] = {8'($urandom), 32'($urandom), c.medium_size};
        n = n + 6;
        for (k = 0; k < n; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            case (idx[k])
                CFG_RESET_TIMEOUT: live_cfg.timeout     = val[k][TIME_W-1:0];
                CFG_WINDOW:        live_cfg.window      = val[k][TIME_W-1:0];
                CFG_FAST_THR:      live_cfg.fast_thr    = val[k][THR_W-1:0];
                CFG_MEDIUM_THR:    live_cfg.medium_thr  = val[k][THR_W-1:0];
                CFG_FAST_STEP:     live_cfg.fast_size   = val[k][SIZE_W-1:0];
                CFG_MEDIUM_STEP:   live_cfg.medium_size = val[k][SIZE_W-1:0];
                default:           ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_event(input int drift, input int end_odds, input bit last_one);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] dt;
        logic [POS_W-1:0]  delta;
        int                r;
        logic              fin;
        span = (live_cfg.window > TIME_W'(1000000)) ? TIME_W'(1000000) : live_cfg.window;
        r = $urandom_range(0, 99);
        if (r < 10)
            dt = '0;
        else if (r < 55)
            dt = TIME_W'($urandom_range(0, 32'(span >> 1)));
        else if (r < 70)
            dt = live_cfg.window + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
        else if (r < 78)
            dt = live_cfg.timeout + TIME_W'($urandom_range(0, 2));
        else
            dt = TIME_W'($urandom_range(0, 32'(span)) * 4);
        if (r >= 88 && r < 95)
            cur_time = cur_time - TIME_W'($urandom_range(0, 32'(span)));
        else if (r >= 95)
            cur_time = TIME_W'({$urandom, $urandom});
        else
            cur_time = cur_time + dt;

        r = $urandom_range(0, 99);
        if (drift != 0)
            delta = POS_W'($urandom_range(0, 3));
        else if (r < 15)
            delta = '0;
        else if (r < 45)
            delta = POS_W'($urandom_range(1, 4));
        else if (r < 65)
            delta = live_cfg.medium_thr + POS_W'($urandom_range(0, 2)) - POS_W'(1);
        else
            delta = live_cfg.fast_thr + POS_W'($urandom_range(0, 2)) - POS_W'(1);
        if (drift < 0 || (drift == 0 && $urandom_range(0, 1) == 1))
            delta = -delta;
        if (drift == 0 && r >= 95)
            cur_pos = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
        else if (drift == 0 && r >= 85)
            cur_pos = POS_W'($urandom);
        else
            cur_pos = cur_pos + delta;
        fin = last_one || (end_odds > 0 && $urandom_range(0, end_odds - 1) == 0);
        send_word(cur_time, cur_pos, fin);
    endtask

    task automatic run_phase(input accel_cfg_t c, input int count, input int drift,
                             input int end_odds, input bit poke_unused, input bit gaps);
        int k;
        drain();
        gaps_on = gaps;
        apply_cfg(c, poke_unused);
        for (k = 0; k < count; k++)
            random_event(drift, end_odds, k == count - 1);
    endtask

    task automatic test_special_cases();
        gaps_on = 1'b1;
        send_word(48'd0, 16'd0, 1'b0);
        send_word(48'd100, 16'd5, 1'b0);
        send_word(48'd200, 16'd20, 1'b0);
        send_word(48'd300, -16'sd10, 1'b0);
        send_word(48'd400, 16'd60, 1'b0);
        send_word(48'd1000000, 16'd7, 1'b0);
        send_word(48'd2000000, 16'd0, 1'b0);
        send_word(48'd3000000, -16'sd3, 1'b1);
        send_word(48'd2500000, 16'd100, 1'b0);
        send_word(48'd12500001, 16'd500, 1'b0);
        send_word(48'd22500001, 16'd1, 1'b0);
        send_word(48'd23000001, 16'd30, 1'b0);
        send_word(48'd23500002, 16'h7FFF, 1'b0);
        send_word(48'd23500003, 16'h8000, 1'b0);
        send_word(48'd23500004, 16'h7FFF, 1'b1);
        send_word(TIME_MAX, -16'sd1, 1'b0);
        send_word(48'd0, 16'd1, 1'b1);
        send_word(48'd600000, 16'd5, 1'b0);
        send_word(48'd1200000, -16'sd5, 1'b1);
    endtask

    task automatic test_default_settings();
        run_phase(pack_regs(RST_RESET_TIMEOUT, RST_WINDOW, RST_FAST_THR, RST_MEDIUM_THR,
                            RST_FAST_STEP, RST_MEDIUM_STEP), 300, 0, 6, 1'b1, 1'b1);
    endtask

    task automatic test_tight_window();
        run_phase(pack_regs(48'd2000, 48'd300, 16'd40, 16'd10, 8'd200, 8'd3),
                  250, 0, 5, 1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        run_phase(pack_regs(48'd1, 48'd1, 16'd0, 16'd0, 8'd255, 8'd255),
                  150, 0, 4, 1'b0, 1'b1);
        run_phase(pack_regs(TIME_MAX, TIME_MAX, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0),
                  150, 0, 4, 1'b1, 1'b1);
    endtask

    task automatic test_batch_saturation();
        accel_cfg_t c;
        c = pack_regs(TIME_MAX, TIME_MAX, 16'd0, 16'd0, 8'd255, 8'd7);
        cur_pos = '0;
        run_phase(c, 160, 1, 0, 1'b0, 1'b1);
        run_phase(c, 160, -1, 0, 1'b0, 1'b1);
    endtask

    task automatic test_random_settings();
        accel_cfg_t c;
        int         k;
        for (k = 0; k < 2; k++)
        begin
            c.window      = TIME_W'($urandom_range(1, 200000));
            c.timeout     = c.window * TIME_W'($urandom_range(1, 20));
            c.fast_thr    = THR_W'($urandom_range(0, 100));
            c.medium_thr  = THR_W'($urandom_range(0, 100));
            c.fast_size   = SIZE_W'($urandom_range(0, 255));
            c.medium_size = SIZE_W'($urandom_range(0, 255));
            run_phase(c, 100, 0, 8, 1'b0, 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got = out_data;
            if (pending_steps.size() == 0)
            begin
                $error("output word with none expected");
                fail_count++;
            end
            else
            begin
                want = pending_steps.pop_front();
                if (got.step !== want.step)
                begin
                    $error("step: expected %0d, got %0d", want.step, got.step);
                    fail_count++;
                end
                if (got.counter_reset !== want.counter_reset)
                begin
                    $error("counter_reset: expected %0b, got %0b",
                           want.counter_reset, got.counter_reset);
                    fail_count++;
                end
                if (got.batch_total !== want.batch_total)
                begin
                    $error("batch_total: expected %0d, got %0d",
                           want.batch_total, got.batch_total);
                    fail_count++;
                end
                if (got.total_ready !== want.total_ready)
                begin
                    $error("total_ready: expected %0b, got %0b",
                           want.total_ready, got.total_ready);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        out_ready  <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        fail_count = 0;
        stall_left = 0;
        gaps_on    = 1'b1;
        batch_acc  = 0;
        cur_time   = '0;
        cur_pos    = '0;
        live_cfg   = pack_regs(RST_RESET_TIMEOUT, RST_WINDOW, RST_FAST_THR, RST_MEDIUM_THR,
                               RST_FAST_STEP, RST_MEDIUM_STEP);
        for (int i = 0; i < ESA_HISTORY_DEPTH; i++)
        begin
            hist_pos[i]  = '0;
            hist_time[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_default_settings();
        test_tight_window();
        test_register_extremes();
        test_batch_saturation();
        test_random_settings();
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[encoder_step_accelerator.f]
design/esa_pkg.sv
design/esa_hist.sv
design/encoder_step_accelerator.sv
bench/encoder_step_accelerator_tb.sv
